// File: rtl/ssmd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Opcodes, register indexes, widths and the digit font shared by the driver.
// ----------------------------------------------------------------------------
package ssmd_pkg;

  // Default number of digit positions and the fixed number of segment lines.
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int SEGMENT_COUNT   = 8;
  localparam int SEG_W           = $clog2(SEGMENT_COUNT);

  // Fixed widths of the beat fields and the configuration port.
  localparam int EN_W    = 4;
  localparam int VALUE_W = 16;
  localparam int CODE_W  = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Digit code that shows nothing.
  localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;

  // Reciprocal of 60 scaled by 2^22; exact for every 16-bit value.
  localparam logic [16:0] RECIP60       = 17'd69906;
  localparam int          RECIP60_SHIFT = 22;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NUMBER  = 2'd1,
    OP_SECONDS = 2'd2,
    OP_DIGIT   = 2'd3
  } opcode_t;

  // Register index, taken from byte address bit 2.
  localparam logic REG_DISPLAY_ON = 1'b0;
  localparam logic REG_DOT_ON     = 1'b1;

  // Font: bit 7 is segment a through bit 1 segment g, bit 0 the dot.
  localparam logic [7:0] SEGMENT_FONT [10] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
  };

  // Segment pattern of one digit code, with the dot added when enabled.
  function automatic logic [7:0] glyph_of(input logic [CODE_W-1:0] code, input logic dot);
    logic [7:0] g;
    g = (code < 4'd10) ? SEGMENT_FONT[code] : 8'h00;
    g[0] = g[0] | dot;
    return g;
  endfunction

endpackage

// File: rtl/seven_segment_mux_driver.sv
// ----------------------------------------------------------------------------
// Seven-segment multiplexed display driver
// Stores decimal digits from number, mm:ss and single-digit writes, and on
// each tick returns the digit enables for the current segment line.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat contents
//   --------+-----------+-------------------------------------------------
//   in      | input     | opcode, value, digit_pos
//   out     | output    | digit_enables, segment_index (ticks only)
//   apb     | config    | 0x0 display_on, 0x4 dot_on
//
// Every beat passes three register stages (input, thousands/seconds split,
// digit extraction) and ticks then land in the output register. One beat is
// taken every cycle while the pipeline is not stalled.
// The pipeline moves as one: it stalls only while a result sits unread in
// the output register. Reset is synchronous; it clears the digits to zero,
// the scan to segment a, display_on to one and dot_on to zero.
//
module seven_segment_mux_driver #(
  parameter int DIGIT_COUNT = ssmd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [ssmd_pkg::VALUE_W-1:0]  value,
  input  logic [1:0]                    digit_pos,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssmd_pkg::EN_W-1:0]     digit_enables,
  output logic [ssmd_pkg::SEG_W-1:0]    segment_index,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssmd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssmd_pkg::DATA_W-1:0]   pwdata,
  output logic [ssmd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ssmd_pkg::*;

  // Only the first four digits have enable outputs.
  localparam int EN_COUNT = (DIGIT_COUNT < EN_W) ? DIGIT_COUNT : EN_W;

  // Configuration registers and display state.
  logic                     display_on;
  logic                     dot_on;
  logic [SEG_W-1:0]         scan_segment;
  logic [CODE_W-1:0]        digit_store      [DIGIT_COUNT];
  logic [CODE_W-1:0]        digit_store_next [DIGIT_COUNT];

  // Pipeline control.
  logic                     adv;
  logic                     v1, v2, v3;

  // Stage 1: input register.
  opcode_t                  op1;
  logic [VALUE_W-1:0]       val1;
  logic [1:0]               pos1;
  logic [13:0]              n_mod1;
  logic [32:0]              prod1;
  logic [10:0]              q60_1;

  // Stage 2: value below 10000 and the minutes quotient.
  opcode_t                  op2;
  logic [VALUE_W-1:0]       val2;
  logic [1:0]               pos2;
  logic [13:0]              n2;
  logic [10:0]              q60_2;
  logic [3:0]               th2;
  logic [9:0]               rem1_2;
  logic [16:0]              sec_full2;
  logic [CODE_W-1:0]        dcode2;

  // Stage 3: thousands digit, remainders, seconds and minutes.
  opcode_t                  op3;
  logic [1:0]               pos3;
  logic [CODE_W-1:0]        dcode3;
  logic [3:0]               th3;
  logic [9:0]               rem1_3;
  logic [5:0]               sec3;
  logic [7:0]               min3;
  logic [6:0]               rem2_3;
  logic [6:0]               mm3;
  logic [CODE_W-1:0]        dig3 [4];
  logic [EN_W-1:0]          en_next;

  // Tens of a value below 100.
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 7'(k * 10)) q = 4'(k);
    end
    return q;
  endfunction

  // Units of a value below 100.
  function automatic logic [3:0] units_of(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 7'(k * 10)) r = x - 7'(k * 10);
    end
    return r[3:0];
  endfunction

  // Hundreds of a value below 1000.
  function automatic logic [3:0] hundreds_of(input logic [9:0] x);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 10'(k * 100)) q = 4'(k);
    end
    return q;
  endfunction

  // Remainder of a value below 1000 after its hundreds.
  function automatic logic [6:0] below_hundred(input logic [9:0] x);
    logic [9:0] r;
    r = x;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 10'(k * 100)) r = x - 10'(k * 100);
    end
    return r[6:0];
  endfunction

  // The whole pipeline advances unless a result waits in the output register.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign pready   = 1'b1;

  // Register read-back.
  assign prdata = {{(DATA_W-1){1'b0}}, (paddr[2] == REG_DOT_ON) ? dot_on : display_on};

  // Stage 1: value modulo 10000 by threshold compares, and value / 60.
  always_comb begin
    n_mod1 = val1[13:0];
    for (int k = 1; k <= 6; k++) begin
      if (val1 >= 16'(k * 10000)) n_mod1 = 14'(val1 - 16'(k * 10000));
    end
    prod1 = 33'(val1) * 33'(RECIP60);
    q60_1 = prod1[RECIP60_SHIFT +: 11];
  end

  // Stage 2: thousands digit, seconds remainder and digit-write code.
  always_comb begin
    th2    = '0;
    rem1_2 = n2[9:0];
    for (int k = 1; k <= 9; k++) begin
      if (n2 >= 14'(k * 1000)) begin
        th2    = 4'(k);
        rem1_2 = 10'(n2 - 14'(k * 1000));
      end
    end
    sec_full2 = 17'(val2) - 17'(q60_2) * 17'd60;
    dcode2    = (val2 > 16'd9) ? BLANK_CODE : val2[CODE_W-1:0];
  end

  // Stage 3: remaining decimal digits for number and mm:ss writes.
  always_comb begin
    rem2_3 = below_hundred(rem1_3);
    if (min3 >= 8'd200) begin
      mm3 = 7'(min3 - 8'd200);
    end else if (min3 >= 8'd100) begin
      mm3 = 7'(min3 - 8'd100);
    end else begin
      mm3 = min3[6:0];
    end
    case (op3)
      OP_NUMBER: begin
        dig3[0] = units_of(rem2_3);
        dig3[1] = tens_of(rem2_3);
        dig3[2] = hundreds_of(rem1_3);
        dig3[3] = th3;
      end
      OP_SECONDS: begin
        dig3[0] = units_of({1'b0, sec3});
        dig3[1] = tens_of({1'b0, sec3});
        dig3[2] = units_of(mm3);
        dig3[3] = tens_of(mm3);
      end
      default: begin
        for (int k = 0; k < 4; k++) dig3[k] = '0;
      end
    endcase
  end

  // Next digit store: right-aligned four-digit load or a single-digit write.
  always_comb begin
    for (int p = 0; p < DIGIT_COUNT; p++) digit_store_next[p] = digit_store[p];
    case (op3)
      OP_NUMBER, OP_SECONDS: begin
        for (int p = 0; p < DIGIT_COUNT; p++) begin
          digit_store_next[p] = '0;
          for (int k = 0; k < 4; k++) begin
            if (p == DIGIT_COUNT - 1 - k) digit_store_next[p] = dig3[k];
          end
        end
      end
      OP_DIGIT: begin
        for (int p = 0; p < DIGIT_COUNT; p++) begin
          if (int'(pos3) == p) digit_store_next[p] = dcode3;
        end
      end
      default: begin
      end
    endcase
  end

  // Digit enables for the current segment line.
  always_comb begin
    logic [7:0] g;
    g       = '0;
    en_next = '0;
    for (int i = 0; i < EN_COUNT; i++) begin
      g          = glyph_of(digit_store[i], dot_on);
      en_next[i] = display_on & g[~scan_segment];
    end
  end

  // Control state: valid bits, scan position, digits and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      out_valid    <= 1'b0;
      scan_segment <= '0;
      display_on   <= 1'b1;
      dot_on       <= 1'b0;
      for (int p = 0; p < DIGIT_COUNT; p++) digit_store[p] <= '0;
    end else begin
      if (adv) begin
        v1        <= in_valid;
        v2        <= v1;
        v3        <= v2;
        out_valid <= v3 && (op3 == OP_TICK);
        if (v3) begin
          for (int p = 0; p < DIGIT_COUNT; p++) digit_store[p] <= digit_store_next[p];
          if ((op3 == OP_TICK) && display_on) scan_segment <= scan_segment + SEG_W'(1);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DOT_ON) begin
          dot_on <= pwdata[0];
        end else begin
          display_on <= pwdata[0];
        end
      end
    end
  end

  // Payload registers of every stage and the result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      op1           <= opcode_t'(opcode);
      val1          <= value;
      pos1          <= digit_pos;
      op2           <= op1;
      val2          <= val1;
      pos2          <= pos1;
      n2            <= n_mod1;
      q60_2         <= q60_1;
      op3           <= op2;
      pos3          <= pos2;
      dcode3        <= dcode2;
      th3           <= th2;
      rem1_3        <= rem1_2;
      sec3          <= sec_full2[5:0];
      min3          <= q60_2[7:0];
      digit_enables <= en_next;
      segment_index <= scan_segment;
    end
  end

`ifndef SYNTHESIS
  // A tick leaving stage 3 becomes a result carrying the scan position it saw.
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && (op3 == OP_TICK)) |=> (out_valid && (segment_index == $past(scan_segment))))
    else $error("tick result missing or carries the wrong segment");

  // With the display on, each tick moves the scan forward by exactly one line.
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && (op3 == OP_TICK) && display_on)
      |=> (scan_segment == $past(scan_segment) + SEG_W'(1)))
    else $error("scan did not advance by one segment");

  // A digit write to the leftmost position stores its code there.
  a_digit_write: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && (op3 == OP_DIGIT) && (pos3 == 2'd0)) |=> (digit_store[0] == $past(dcode3)))
    else $error("digit write not stored");
`endif

endmodule
